@@ rtl/core/dpfp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dpfp_pkg
// Shared types, character codes and helpers of the DOS path to FCB parser.
// ----------------------------------------------------------------------------
package dpfp_pkg;

  localparam int unsigned DefNameLen = 8;
  localparam int unsigned DefExtLen  = 3;
  localparam int unsigned CmdqDepth  = 2;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChBsl   = 8'h5c;

  // Shift-JIS lead bytes fold into one window after flipping bit 5.
  localparam logic [7:0] LeadLow  = 8'ha1;
  localparam logic [7:0] LeadSpan = 8'h3c;

  localparam logic [1:0] KindDir   = 2'd0;
  localparam logic [1:0] KindFinal = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  typedef enum logic [2:0] {
    PhStart = 3'b001,
    PhName  = 3'b010,
    PhExt   = 3'b100
  } dpfp_phase_e;

  // Command from the parsing front to the result back end.
  typedef struct packed {
    logic is_err;
    logic is_final;
  } dpfp_cmd_hdr_t;

  function automatic logic is_lead(input logic [7:0] c);
    logic [7:0] t;
    t = (c ^ ChSpace) - LeadLow;
    return (t < LeadSpan);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/dos_path_to_fcb_parser.sv @@
`default_nettype none
// A byte that ends a component or raises an error passes the command queue and
// then the back end's output register before its first result shows; a component
// drains NameLen+ExtLen results, one per cycle while pop is given; an error, one.
// Throughput: one path byte per cycle while the two-entry command queue has room.
// Reset: asynchronous, clears all control state and sets the name buffer to
// spaces at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// dos_path_to_fcb_parser
// Splits a zero-terminated DOS path into space-padded 8.3 FCB names.
// ----------------------------------------------------------------------------
module dos_path_to_fcb_parser import dpfp_pkg::*; #(
  parameter int unsigned NameLen = DefNameLen,
  parameter int unsigned ExtLen  = DefExtLen
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  path_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       fcb_byte_o,
  output logic [3:0]       byte_index_o,
  output logic [1:0]       component_kind_o,
  output logic             status_o,
  output logic             last_o
);

  localparam int unsigned FcbLen = NameLen + ExtLen;

  logic                    q_full;
  logic                    byte_take;
  logic                    fr_valid;
  dpfp_cmd_hdr_t           fr_hdr;
  logic [FcbLen-1:0][7:0]  fr_bytes;
  logic                    q_valid;
  dpfp_cmd_hdr_t           q_hdr;
  logic [FcbLen-1:0][7:0]  q_bytes;
  logic                    q_pop;
  logic                    out_valid;

  // Any byte may finish a component, so bytes wait while the queue is full.
  assign full      = q_full;
  assign byte_take = push && !q_full;
  assign empty     = !out_valid;

  dpfp_front #(
    .NameLen (NameLen),
    .ExtLen  (ExtLen)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_take),
    .path_byte_i  (path_byte_i),
    .cmd_valid_o  (fr_valid),
    .cmd_hdr_o    (fr_hdr),
    .cmd_bytes_o  (fr_bytes)
  );

  dpfp_cmdq #(
    .FcbLen (FcbLen)
  ) u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_hdr_i   (fr_hdr),
    .wr_bytes_i (fr_bytes),
    .full_o     (q_full),
    .rd_valid_o (q_valid),
    .rd_hdr_o   (q_hdr),
    .rd_bytes_o (q_bytes),
    .rd_pop_i   (q_pop)
  );

  dpfp_back #(
    .FcbLen (FcbLen)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_hdr_i        (q_hdr),
    .cmd_bytes_i      (q_bytes),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid),
    .out_take_i       (pop),
    .fcb_byte_o       (fcb_byte_o),
    .byte_index_o     (byte_index_o),
    .component_kind_o (component_kind_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/dpfp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dpfp_front
// Parses path bytes into the name buffer and issues one command per finished
// component or per error.
// ----------------------------------------------------------------------------
module dpfp_front import dpfp_pkg::*; #(
  parameter int unsigned NameLen = DefNameLen,
  parameter int unsigned ExtLen  = DefExtLen
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              byte_valid_i,
  input  wire logic [7:0]                        path_byte_i,
  output logic                                   cmd_valid_o,
  output dpfp_cmd_hdr_t                          cmd_hdr_o,
  output logic [NameLen+ExtLen-1:0][7:0]         cmd_bytes_o
);

  localparam int unsigned FcbLen = NameLen + ExtLen;
  localparam int unsigned MaxLen = (NameLen > ExtLen) ? NameLen : ExtLen;
  localparam int unsigned PosW   = $clog2(MaxLen + 3);
  localparam int unsigned SumW   = $clog2(FcbLen + 3);
  localparam logic [PosW-1:0] NameLenP = PosW'(NameLen);
  localparam logic [PosW-1:0] ExtLenP  = PosW'(ExtLen);
  localparam logic [SumW-1:0] ExtBase  = SumW'(NameLen);

  dpfp_phase_e                  phase_q, phase_d;
  logic [PosW-1:0]              pos_q, pos_d;
  logic [7:0]                   pend_q, pend_d;
  logic                         lead_q, lead_d;
  logic                         skip_q, skip_d;
  logic [FcbLen-1:0][7:0]       buf_q, buf_d;

  logic                         in_ext;
  logic [PosW-1:0]              len;
  logic [SumW-1:0]              wr_idx;
  logic                         wr_a, wr_b;
  logic [7:0]                   wr_byte_a;
  logic                         do_emit, do_fail, emit_final, fail_at_end;
  logic [7:0]                   c;

  assign c      = path_byte_i;
  assign in_ext = (phase_q == PhExt);
  assign len    = in_ext ? ExtLenP : NameLenP;
  assign wr_idx = (in_ext ? ExtBase : '0) + SumW'(pos_q);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    lead_d      = lead_q;
    skip_d      = skip_q;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    wr_byte_a   = c;
    do_emit     = 1'b0;
    do_fail     = 1'b0;
    emit_final  = 1'b0;
    fail_at_end = 1'b0;
    if (byte_valid_i) begin
      if (skip_q) begin
        if (c == ChNul) skip_d = 1'b0;
      end else if (phase_q == PhStart) begin
        priority if (c == ChNul) begin
          do_emit    = 1'b1;
          emit_final = 1'b1;
        end else if (c == ChBsl) begin
          phase_d = PhName;
          pos_d   = '0;
        end else begin
          do_fail = 1'b1;
        end
      end else if (lead_q) begin
        if (c == ChNul) begin
          do_fail     = 1'b1;
          fail_at_end = 1'b1;
        end else begin
          // Room for the pair was checked when the lead byte arrived.
          wr_a      = 1'b1;
          wr_b      = 1'b1;
          wr_byte_a = pend_q;
          pos_d     = pos_q + PosW'(2);
          lead_d    = 1'b0;
          pend_d    = ChNul;
        end
      end else begin
        priority if (c == ChNul) begin
          phase_d    = PhStart;
          do_emit    = 1'b1;
          emit_final = 1'b1;
        end else if (c == ChBsl) begin
          phase_d = PhName;
          do_emit = 1'b1;
        end else if (c == ChDot) begin
          if (in_ext) begin
            do_fail = 1'b1;
          end else begin
            phase_d = PhExt;
            pos_d   = '0;
          end
        end else if (pos_q >= len) begin
          do_fail = 1'b1;
        end else if (is_lead(c)) begin
          if (pos_q + PosW'(2) > len) begin
            do_fail = 1'b1;
          end else begin
            pend_d = c;
            lead_d = 1'b1;
          end
        end else begin
          wr_a  = 1'b1;
          pos_d = pos_q + PosW'(1);
        end
      end
    end

    buf_d = buf_q;
    for (int unsigned i = 0; i < FcbLen; i++) begin
      if (wr_a && (wr_idx == SumW'(i))) buf_d[i] = wr_byte_a;
      if (wr_b && ((wr_idx + SumW'(1)) == SumW'(i))) buf_d[i] = c;
    end

    if (do_emit || do_fail) begin
      buf_d  = {FcbLen{ChSpace}};
      pos_d  = '0;
      lead_d = 1'b0;
      pend_d = ChNul;
    end
    if (do_fail) begin
      phase_d = PhStart;
      skip_d  = !fail_at_end;
    end
  end

  assign cmd_valid_o        = do_emit || do_fail;
  assign cmd_hdr_o.is_err   = do_fail;
  assign cmd_hdr_o.is_final = emit_final;
  assign cmd_bytes_o        = buf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      pos_q   <= '0;
      pend_q  <= ChNul;
      lead_q  <= 1'b0;
      skip_q  <= 1'b0;
      buf_q   <= {FcbLen{ChSpace}};
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      lead_q  <= lead_d;
      skip_q  <= skip_d;
      buf_q   <= buf_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dpfp_cmdq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dpfp_cmdq
// Short command queue between the parsing front and the result back end.
// ----------------------------------------------------------------------------
module dpfp_cmdq import dpfp_pkg::*; #(
  parameter int unsigned FcbLen = DefNameLen + DefExtLen
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      wr_valid_i,
  input  wire dpfp_cmd_hdr_t             wr_hdr_i,
  input  wire logic [FcbLen-1:0][7:0]    wr_bytes_i,
  output logic                           full_o,
  output logic                           rd_valid_o,
  output dpfp_cmd_hdr_t                  rd_hdr_o,
  output logic [FcbLen-1:0][7:0]         rd_bytes_o,
  input  wire logic                      rd_pop_i
);

  localparam int unsigned PtrW = $clog2(CmdqDepth);
  localparam int unsigned CntW = $clog2(CmdqDepth + 1);

  dpfp_cmd_hdr_t          hdr_q   [CmdqDepth];
  logic [FcbLen-1:0][7:0] bytes_q [CmdqDepth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        cnt_q;
  logic                   do_wr, do_rd;

  assign full_o     = (cnt_q == CntW'(CmdqDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_hdr_o   = hdr_q[rd_ptr_q];
  assign rd_bytes_o = bytes_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrW'(CmdqDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrW'(CmdqDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      hdr_q[wr_ptr_q]   <= wr_hdr_i;
      bytes_q[wr_ptr_q] <= wr_bytes_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dpfp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dpfp_back
// Turns each queued command into result transactions, one per cycle while the
// output is taken, through an output register.
// ----------------------------------------------------------------------------
module dpfp_back import dpfp_pkg::*; #(
  parameter int unsigned FcbLen = DefNameLen + DefExtLen
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  input  wire dpfp_cmd_hdr_t             cmd_hdr_i,
  input  wire logic [FcbLen-1:0][7:0]    cmd_bytes_i,
  output logic                           cmd_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_take_i,
  output logic [7:0]                     fcb_byte_o,
  output logic [3:0]                     byte_index_o,
  output logic [1:0]                     component_kind_o,
  output logic                           status_o,
  output logic                           last_o
);

  localparam int unsigned KW = $clog2(FcbLen);

  logic [KW-1:0]   k_q;
  logic [KW+3:0]   k_ext;
  logic            vld_q;
  logic            load;
  logic            k_last;
  logic [7:0]      byte_q;
  logic [3:0]      idx_q;
  logic [1:0]      kind_q;
  logic            stat_q, last_q;

  assign load      = cmd_valid_i && (!vld_q || out_take_i);
  assign k_last    = (k_q == KW'(FcbLen - 1));
  assign k_ext     = {4'b0000, k_q};
  assign cmd_pop_o = load && (cmd_hdr_i.is_err || k_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
      end else if (out_take_i) begin
        vld_q <= 1'b0;
      end
      if (load && !cmd_hdr_i.is_err) begin
        k_q <= k_last ? '0 : k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (cmd_hdr_i.is_err) begin
        byte_q <= ChNul;
        idx_q  <= 4'd0;
        kind_q <= KindError;
        stat_q <= 1'b1;
        last_q <= 1'b1;
      end else begin
        byte_q <= cmd_bytes_i[k_q];
        idx_q  <= k_ext[3:0];
        kind_q <= cmd_hdr_i.is_final ? KindFinal : KindDir;
        stat_q <= 1'b0;
        last_q <= k_last;
      end
    end
  end

  assign out_valid_o      = vld_q;
  assign fcb_byte_o       = byte_q;
  assign byte_index_o     = idx_q;
  assign component_kind_o = kind_q;
  assign status_o         = stat_q;
  assign last_o           = last_q;

endmodule
`default_nettype wire
